@@ sv/bbr_pkg.sv @@
package bbr_pkg;

  localparam int MAX_ROW_BYTES = 4096;
  localparam int MAX_ROWS      = 4096;
  localparam int PAD_BYTES     = 6;
  localparam int STORE_DEPTH   = MAX_ROW_BYTES + PAD_BYTES;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int POS_W         = 13;
  localparam int CFG_W         = 13;
  localparam int WIN_COLS      = 7;
  localparam int TAP_MID       = WIN_COLS / 2;
  localparam int TAP_NEW       = WIN_COLS - 1;
  localparam int SUM_W         = 12;

  // floor(sum * 111 / 1000) == (sum * RECIP) >> RECIP_SHIFT for every sum up to 9*255
  localparam int RECIP_SHIFT   = 20;
  localparam int RECIP_W       = 17;
  localparam logic [RECIP_W-1:0] RECIP = 17'd116392;
  localparam int PROD_W        = SUM_W + RECIP_W;

  localparam logic [CFG_W-1:0] RESET_ROW_BYTES = 13'd3;
  localparam logic [CFG_W-1:0] RESET_ROW_COUNT = 13'd1;

  localparam logic REG_ROW_BYTES = 1'b0;
  localparam logic REG_ROW_COUNT = 1'b1;

  // two stored rows at one column
  typedef struct packed {
    logic [7:0] up;
    logic [7:0] mid;
  } pair_t;

  // one window column: upper, middle and current row
  typedef struct packed {
    logic [7:0] up;
    logic [7:0] mid;
    logic [7:0] cur;
  } col_t;

endpackage

@@ sv/bbr_line_store.sv @@
module bbr_line_store import bbr_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  pair_t             wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output pair_t             rdata_o
);

  pair_t mem [STORE_DEPTH];
  pair_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // hold read data until the next request
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/bbr_cell.sv @@
module bbr_cell import bbr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_i,
  input  col_t col_i,
  output col_t col_o
);

  col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

@@ sv/box_blur_3x3_rgb.sv @@
// Throughput: one byte per cycle unless out_stall_i backs up the pipeline, set by the
// line store doing one read and one write per cycle and by the seven-cell window
// shifting once per byte.
// Reset clears counters and window, sets row_bytes to 3 and row_count to 1;
// the line store is not cleared and needs no clearing pass.
module box_blur_3x3_rgb import bbr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       pixel_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       blurred_byte_o,
  output logic             last_o
);

  function automatic logic [POS_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] hi);
    logic [POS_W-1:0] r;
    if (v == '0) begin
      r = POS_W'(1);
    end else if (v > hi) begin
      r = POS_W'(hi);
    end else begin
      r = POS_W'(v);
    end
    return r;
  endfunction

  // configuration, kept as last column and last row of the padded fragment
  logic [POS_W-1:0] col_last_q, col_last_d;
  logic [POS_W-1:0] row_last_q, row_last_d;

  logic [POS_W-1:0] col_q, col_d;
  logic [POS_W-1:0] row_q, row_d;

  // pipeline control
  logic vb_q, vc_q, vd_q, ve_q;
  logic emit_b_q, last_b_q, last_c_q, last_d_q, last_e_q;
  logic rdy_b, rdy_c, rdy_d, rdy_e;
  logic move_b, move_c, move_d;
  logic acc;

  // pipeline payload
  logic [7:0]        px_b_q;
  logic [ADDR_W-1:0] addr_b_q;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [PROD_W-1:0] prod_q, prod_d;

  logic row_end, frag_end, emit;

  pair_t rd_pair, wr_pair;
  col_t  new_col;
  col_t  win_col [WIN_COLS];

  assign rdy_e  = !ve_q || !out_stall_i;
  assign rdy_d  = !vd_q || rdy_e;
  assign move_d = vd_q && rdy_e;
  assign rdy_c  = !vc_q || rdy_d;
  assign move_c = vc_q && rdy_d;
  assign rdy_b  = !vb_q || rdy_c;
  assign move_b = vb_q && rdy_c;

  assign in_stall_o = !rdy_b;
  assign acc        = in_valid_i && rdy_b;

  assign row_end  = col_q >= col_last_q;
  assign frag_end = row_end && (row_q >= row_last_q);
  assign emit     = (row_q >= POS_W'(2)) && (col_q >= POS_W'(PAD_BYTES));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (acc) begin
      if (frag_end) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = row_q + POS_W'(1);
      end else begin
        col_d = col_q + POS_W'(1);
      end
    end
  end

  always_comb begin
    col_last_d = col_last_q;
    row_last_d = row_last_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROW_BYTES: col_last_d = clamp_cfg(cfg_data_i, CFG_W'(MAX_ROW_BYTES))
                                    + POS_W'(PAD_BYTES - 1);
        REG_ROW_COUNT: row_last_d = clamp_cfg(cfg_data_i, CFG_W'(MAX_ROWS)) + POS_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_last_q <= RESET_ROW_BYTES + POS_W'(PAD_BYTES - 1);
      row_last_q <= RESET_ROW_COUNT + POS_W'(1);
      col_q      <= '0;
      row_q      <= '0;
      vb_q       <= 1'b0;
      vc_q       <= 1'b0;
      vd_q       <= 1'b0;
      ve_q       <= 1'b0;
    end else begin
      col_last_q <= col_last_d;
      row_last_q <= row_last_d;
      col_q      <= col_d;
      row_q      <= row_d;
      if (acc) begin
        vb_q <= 1'b1;
      end else if (move_b) begin
        vb_q <= 1'b0;
      end
      // only requests that produce a result go past the window
      if (move_b) begin
        vc_q <= emit_b_q;
      end else if (move_c) begin
        vc_q <= 1'b0;
      end
      if (move_c) begin
        vd_q <= 1'b1;
      end else if (move_d) begin
        vd_q <= 1'b0;
      end
      if (move_d) begin
        ve_q <= 1'b1;
      end else if (rdy_e) begin
        ve_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      px_b_q   <= pixel_byte_i;
      addr_b_q <= ADDR_W'(col_q);
      emit_b_q <= emit;
      last_b_q <= frag_end;
    end
    if (move_b) begin
      last_c_q <= last_b_q;
    end
    if (move_c) begin
      sum_q    <= sum_d;
      last_d_q <= last_c_q;
    end
    if (move_d) begin
      prod_q   <= prod_d;
      last_e_q <= last_d_q;
    end
  end

  // line store: read at accept, write back the shifted column when the byte moves on from the input register
  assign wr_pair.up  = rd_pair.mid;
  assign wr_pair.mid = px_b_q;

  bbr_line_store u_line_store (
    .clk_i   (clk_i),
    .we_i    (move_b),
    .waddr_i (addr_b_q),
    .wdata_i (wr_pair),
    .re_i    (acc),
    .raddr_i (ADDR_W'(col_q)),
    .rdata_o (rd_pair)
  );

  assign new_col.up  = rd_pair.up;
  assign new_col.mid = rd_pair.mid;
  assign new_col.cur = px_b_q;

  // window: cell 0 holds the oldest column, the newest enters at the far end
  for (genvar k = 0; k < WIN_COLS; k++) begin : g_win
    col_t cell_in;
    if (k == WIN_COLS - 1) begin : g_head
      assign cell_in = new_col;
    end else begin : g_body
      assign cell_in = win_col[k+1];
    end
    bbr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (move_b),
      .col_i   (cell_in),
      .col_o   (win_col[k])
    );
  end

  always_comb begin
    sum_d = SUM_W'(win_col[0].up) + SUM_W'(win_col[0].mid) + SUM_W'(win_col[0].cur)
          + SUM_W'(win_col[TAP_MID].up) + SUM_W'(win_col[TAP_MID].mid)
          + SUM_W'(win_col[TAP_MID].cur)
          + SUM_W'(win_col[TAP_NEW].up) + SUM_W'(win_col[TAP_NEW].mid)
          + SUM_W'(win_col[TAP_NEW].cur);
  end

  assign prod_d = PROD_W'(sum_q) * PROD_W'(RECIP);

  assign out_valid_o    = ve_q;
  assign blurred_byte_o = prod_q[RECIP_SHIFT +: 8];
  assign last_o         = last_e_q;

`ifndef ASSERT_OFF
  // the window must not shift while a result still needs its contents
  a_window_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vc_q && !move_c) |-> !move_b)
    else $error("window shifted under a pending sum");

  // write-back and new read never collide on one column
  a_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && move_b) |-> (addr_b_q != ADDR_W'(col_q)))
    else $error("line store read and write at the same column");

  // counters restart after the final byte of a fragment
  a_frag_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && frag_end) |=> (col_q == '0) && (row_q == '0))
    else $error("counters did not restart after fragment end");

  // scaled result always fits the output byte
  a_result_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ve_q |-> (prod_q[PROD_W-1 -: (PROD_W - RECIP_SHIFT - 8)] == '0))
    else $error("scaled result overflows the output byte");
`endif

endmodule

@@ bench/box_blur_3x3_rgb_test.sv @@
`timescale 1ns / 1ps

module box_blur_3x3_rgb_test;
  import bbr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int RANDOM_BYTES = 1400;

  typedef enum {GAP_FULL, GAP_SPARSE, GAP_NONE} gap_mode_e;
  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_FULL, FILL_EXTREME, FILL_DIM} fill_e;

  typedef struct packed {
    logic [7:0] blurred;
    logic       last;
  } blur_out_t;

  // Tracks line stores, window and counters; holds the blurred bytes still owed.
  class blur_ledger;
    bit [7:0]         upper_row [STORE_DEPTH];
    bit [7:0]         middle_row [STORE_DEPTH];
    bit [7:0]         win [3][WIN_COLS];
    int unsigned      col;
    int unsigned      row;
    logic [CFG_W-1:0] row_bytes;
    logic [CFG_W-1:0] row_count;
    blur_out_t        owed[$];
    int               errors;

    function new();
      col = 0;
      row = 0;
      row_bytes = RESET_ROW_BYTES;
      row_count = RESET_ROW_COUNT;
      errors = 0;
    endfunction

    static function int unsigned padded_width(logic [CFG_W-1:0] rb);
      int unsigned w;
      w = rb;
      if (w < 1) w = 1;
      if (w > MAX_ROW_BYTES) w = MAX_ROW_BYTES;
      return w + PAD_BYTES;
    endfunction

    static function int unsigned padded_rows(logic [CFG_W-1:0] rc);
      int unsigned n;
      n = rc;
      if (n < 1) n = 1;
      if (n > MAX_ROWS) n = MAX_ROWS;
      return n + 2;
    endfunction

    function void set_reg(logic idx, logic [CFG_W-1:0] val);
      if (idx == REG_ROW_BYTES) row_bytes = val;
      else row_count = val;
    endfunction

    function void accept_byte(logic [7:0] px);
      int unsigned width;
      int unsigned rows;
      int unsigned sum;
      bit [7:0]    up;
      bit [7:0]    mid;
      bit          row_end;
      bit          frag_end;
      blur_out_t   res;
      width = padded_width(row_bytes);
      rows = padded_rows(row_count);
      row_end = (col >= width - 1);
      frag_end = row_end && (row >= rows - 1);
      up = upper_row[col];
      mid = middle_row[col];
      upper_row[col] = mid;
      middle_row[col] = px;
      for (int k = 0; k < WIN_COLS - 1; k++) begin
        for (int i = 0; i < 3; i++) win[i][k] = win[i][k+1];
      end
      win[0][TAP_NEW] = up;
      win[1][TAP_NEW] = mid;
      win[2][TAP_NEW] = px;
      if (row >= 2 && col >= PAD_BYTES) begin
        sum = 0;
        for (int i = 0; i < 3; i++) begin
          sum += int'(win[i][0]) + int'(win[i][TAP_MID]) + int'(win[i][TAP_NEW]);
        end
        res.blurred = 8'((sum * 111) / 1000);
        res.last = frag_end;
        owed.push_back(res);
      end
      if (frag_end) begin
        col = 0;
        row = 0;
      end else if (row_end) begin
        col = 0;
        row = row + 1;
      end else begin
        col = col + 1;
      end
    endfunction

    function void check_output(logic [7:0] b, logic l);
      blur_out_t want;
      if (owed.size() == 0) begin
        $error("unexpected output: blurred_byte %0d, last %0b", b, l);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (b !== want.blurred) begin
        $error("blurred_byte: expected %0d, got %0d", want.blurred, b);
        errors++;
      end
      if (l !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, l);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [7:0]       pixel_byte_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [7:0]       blurred_byte_o;
  logic             last_o;

  blur_ledger  ledger;
  gap_mode_e   gap_mode = GAP_FULL;
  int unsigned cycle_count = 0;

  box_blur_3x3_rgb dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_byte_i  (pixel_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .blurred_byte_o(blurred_byte_o),
    .last_o        (last_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int draw_gap();
    case (gap_mode)
      GAP_NONE:   return 0;
      GAP_SPARSE: return ($urandom_range(0, 15) == 0) ? $urandom_range(0, 19) : 0;
      default:    return $urandom_range(0, 19);
    endcase
  endfunction

  function automatic logic [7:0] pick_byte(fill_e fill);
    case (fill)
      FILL_ZERO:    return 8'h00;
      FILL_FULL:    return 8'hff;
      FILL_EXTREME: return $urandom_range(0, 1) ? 8'hff : 8'h00;
      FILL_DIM:     return 8'($urandom_range(0, 15));
      default:      return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_byte(logic [7:0] px);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_byte_i <= px;
    do @(posedge clk_i); while (in_stall_o);
    ledger.accept_byte(px);
  endtask

  task automatic send_fragment(int unsigned count, fill_e fill);
    for (int unsigned n = 0; n < count; n++) send_byte(pick_byte(fill));
  endtask

  task automatic set_geometry(logic [CFG_W-1:0] rb, logic [CFG_W-1:0] rc);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_ROW_BYTES;
    cfg_data_i <= rb;
    @(posedge clk_i);
    cfg_idx_i <= REG_ROW_COUNT;
    cfg_data_i <= rc;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ledger.set_reg(REG_ROW_BYTES, rb);
    ledger.set_reg(REG_ROW_COUNT, rc);
  endtask

  // hold input until every owed byte is out, then let the pipeline settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (ledger.owed.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_geometry(logic [CFG_W-1:0] rb, logic [CFG_W-1:0] rc, int frags,
                              output int unsigned bytes);
    fill_e fill;
    bytes = 0;
    set_geometry(rb, rc);
    repeat (frags) begin
      case ($urandom_range(0, 9))
        0:       fill = FILL_ZERO;
        1:       fill = FILL_FULL;
        2:       fill = FILL_EXTREME;
        3:       fill = FILL_DIM;
        default: fill = FILL_RANDOM;
      endcase
      send_fragment(blur_ledger::padded_width(rb) * blur_ledger::padded_rows(rc), fill);
      bytes += blur_ledger::padded_width(rb) * blur_ledger::padded_rows(rc);
    end
    drain();
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("box_blur_3x3_rgb test failed");
    $finish;
  end

  // output side: random stall before each request
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      ledger.check_output(blurred_byte_o, last_o);
    end
  end

  initial begin
    int unsigned      sent;
    int unsigned      bytes;
    logic [CFG_W-1:0] rb;
    logic [CFG_W-1:0] rc;
    ledger = new();
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_ROW_BYTES;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    pixel_byte_i <= '0;
    out_stall_i <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // geometry left by reset, then zero registers acting as one with a saturated sum
    send_fragment(blur_ledger::padded_width(RESET_ROW_BYTES) *
                  blur_ledger::padded_rows(RESET_ROW_COUNT), FILL_RANDOM);
    drain();
    set_geometry('0, '0);
    send_fragment(blur_ledger::padded_width('0) * blur_ledger::padded_rows('0), FILL_FULL);
    drain();

    sent = 0;
    while (sent < RANDOM_BYTES) begin
      case ($urandom_range(0, 7))
        0:       rb = '0;
        1:       rb = CFG_W'(1);
        2:       rb = CFG_W'($urandom_range(13, 48));
        default: rb = CFG_W'($urandom_range(2, 12));
      endcase
      case ($urandom_range(0, 7))
        0:       rc = '0;
        1:       rc = CFG_W'(1);
        2:       rc = CFG_W'($urandom_range(6, 16));
        default: rc = CFG_W'($urandom_range(2, 5));
      endcase
      gap_mode = ($urandom_range(0, 3) == 0) ? GAP_NONE : GAP_FULL;
      run_geometry(rb, rc, $urandom_range(1, 3), bytes);
      sent += bytes;
    end

    gap_mode = GAP_SPARSE;
    run_geometry(CFG_W'($urandom_range(2, 12)), CFG_W'($urandom_range(1, 4)), 2, bytes);

    if (ledger.errors == 0 && ledger.owed.size() == 0) begin
      $display("box_blur_3x3_rgb test passed");
    end else begin
      $display("box_blur_3x3_rgb test failed");
    end
    $finish;
  end

endmodule
